// File: rtl/bck_pkg.sv
// Package for the barometer compensation and Kalman smoothing block.
// Holds payload structs, register indexes and reset constants; no dependencies.
package bck_pkg;
	localparam int EXTRA_BITS_DEF = 0;
	localparam int NUM_REGS = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [2:0] REG_C1 = 3'd0;
	localparam logic [2:0] REG_C2 = 3'd1;
	localparam logic [2:0] REG_C3 = 3'd2;
	localparam logic [2:0] REG_C4 = 3'd3;
	localparam logic [2:0] REG_C5 = 3'd4;
	localparam logic [2:0] REG_C6 = 3'd5;
	localparam logic [2:0] REG_Q = 3'd6;
	localparam logic [2:0] REG_R = 3'd7;

	localparam logic [31:0] Q_RESET = 32'd3277;
	localparam logic [31:0] R_RESET = 32'd13107200;
	localparam logic [31:0] COV_RESET = 32'd6553600;

	typedef struct packed {
		logic [23:0] pressure_conversion;
		logic [23:0] temperature_conversion;
	} in_word_t;

	typedef struct packed {
		logic signed [14:0] temperature_tenths;
		logic signed [31:0] pressure_pascal;
		logic signed [39:0] filtered_pressure;
	} out_word_t;

	// Word handed from the compensation front to the filter back.
	typedef struct packed {
		logic signed [14:0] temperature_tenths;
		logic signed [31:0] pressure_pascal;
	} comp_word_t;
endpackage

// File: rtl/baro_compensate_kalman_smooth_top.sv
// Barometer compensation and Kalman smoother, top level.
// Usage: feed raw D1/D2 words on in_valid/in_ready, take results on
// out_valid/out_ready. Write calibration and noise registers through
// cfg_we/cfg_index/cfg_data while the block is idle; a write takes effect at once.
// Front: compensation of one word at a time. Back: Kalman update, with the
// gain from the 17-step serial divider; it takes a new word only when done
// with the last. A two-word queue sits between them, so the front keeps
// accepting while the back divides. Reset clears registers to their
// defaults, the estimate to unseeded and the covariance to 100.0. When the
// receiver stalls the result holds, the queue fills, and then in_ready falls.
// Depends on bck_pkg, bck_front, bck_queue, bck_back.
module baro_compensate_kalman_smooth_top #(
	parameter int EXTRA_BITS = bck_pkg::EXTRA_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bck_pkg::in_word_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bck_pkg::out_word_t                out_data,
	input  logic                              cfg_we,
	input  logic [bck_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bck_pkg::CFG_DATA_W-1:0]    cfg_data
);
	logic [15:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	logic [31:0] q_q, r_q;
	logic fv, fr, bv, br;
	bck_pkg::comp_word_t fd, bd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0; c2_q <= '0; c3_q <= '0;
			c4_q <= '0; c5_q <= '0; c6_q <= '0;
			q_q <= bck_pkg::Q_RESET;
			r_q <= bck_pkg::R_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bck_pkg::REG_C1: c1_q <= cfg_data[15:0];
				bck_pkg::REG_C2: c2_q <= cfg_data[15:0];
				bck_pkg::REG_C3: c3_q <= cfg_data[15:0];
				bck_pkg::REG_C4: c4_q <= cfg_data[15:0];
				bck_pkg::REG_C5: c5_q <= cfg_data[15:0];
				bck_pkg::REG_C6: c6_q <= cfg_data[15:0];
				bck_pkg::REG_Q: q_q <= cfg_data;
				bck_pkg::REG_R: r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bck_front #(.EXTRA_BITS(EXTRA_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.c1(c1_q), .c2(c2_q), .c3(c3_q), .c4(c4_q), .c5(c5_q), .c6(c6_q),
		.out_valid(fv), .out_ready(fr), .out_data(fd)
	);

	bck_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(fv), .in_ready(fr), .in_data(fd),
		.out_valid(bv), .out_ready(br), .out_data(bd)
	);

	bck_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(bv), .in_ready(br), .in_data(bd),
		.q(q_q), .r(r_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

// File: rtl/bck_front.sv
// Front end: first-order compensation of one raw pair at a time.
// Depends on bck_pkg.
module bck_front #(
	parameter int EXTRA_BITS = bck_pkg::EXTRA_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bck_pkg::in_word_t   in_data,
	input  logic [15:0]         c1,
	input  logic [15:0]         c2,
	input  logic [15:0]         c3,
	input  logic [15:0]         c4,
	input  logic [15:0]         c5,
	input  logic [15:0]         c6,
	output logic                out_valid,
	input  logic                out_ready,
	output bck_pkg::comp_word_t out_data
);
	// Reciprocal of ten scaled by 2^21; exact for magnitudes below 2^18.
	localparam logic [35:0] TEN_RECIP = 36'd209716;

	typedef enum logic [5:0] {
		F_IDLE = 6'b000001,
		F_S1   = 6'b000010,
		F_S2   = 6'b000100,
		F_S3   = 6'b001000,
		F_S4   = 6'b010000,
		F_OUT  = 6'b100000
	} fstate_t;

	fstate_t state_q;
	logic [23:0] d1_q;
	logic signed [24:0] dt_q;
	logic signed [40:0] tprod_q, offp_q, sensp_q;
	logic signed [47:0] sens_q, off_q;
	logic signed [72:0] d1s_q;
	logic [17:0] tabs_q;
	logic tneg_q;
	bck_pkg::comp_word_t res_q;

	logic signed [47:0] temp_w;
	logic signed [47:0] pr_w, pr_f;
	logic signed [47:0] pr_t;
	logic [35:0] tmul_w;
	logic [14:0] tmag_w;

	// Temperature in hundredths, then tenths truncated toward zero.
	assign temp_w = 48'sd2000 + 48'(tprod_q >>> 23);
	assign tmul_w = 36'(tabs_q) * TEN_RECIP;
	assign tmag_w = tmul_w[35:21];

	// Pressure before saturation.
	always_comb begin
		pr_w = 48'(d1s_q >>> 21) - off_q;
		pr_f = pr_w >>> (15 - EXTRA_BITS);
		if (pr_f < 0)
			pr_t = -((-pr_f) >>> EXTRA_BITS);
		else
			pr_t = pr_f >>> EXTRA_BITS;
	end

	assign in_ready = (state_q == F_IDLE);
	assign out_valid = (state_q == F_OUT);
	assign out_data = res_q;

	// Sequencer: at most one multiplier rank per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (in_valid) state_q <= F_S1;
				F_S1: state_q <= F_S2;
				F_S2: state_q <= F_S3;
				F_S3: state_q <= F_S4;
				F_S4: state_q <= F_OUT;
				F_OUT: if (out_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				d1_q <= in_data.pressure_conversion;
				dt_q <= $signed({1'b0, in_data.temperature_conversion})
					- $signed({1'b0, c5, 8'd0});
			end
			F_S1: begin
				tprod_q <= 41'(dt_q * $signed({1'b0, c6}));
				offp_q <= 41'(dt_q * $signed({1'b0, c4}));
				sensp_q <= 41'(dt_q * $signed({1'b0, c3}));
			end
			F_S2: begin
				off_q <= $signed({16'd0, c2, 16'd0}) + 48'(offp_q >>> 7);
				sens_q <= $signed({17'd0, c1, 15'd0}) + 48'(sensp_q >>> 8);
				tneg_q <= temp_w[47];
				tabs_q <= temp_w[47] ? 18'(-temp_w) : 18'(temp_w);
			end
			F_S3: begin
				d1s_q <= 73'($signed({1'b0, d1_q}) * sens_q);
				res_q.temperature_tenths <= tneg_q ? -tmag_w : tmag_w;
			end
			F_S4: begin
				if (pr_t > 48'sh7FFFFFFF)
					res_q.pressure_pascal <= 32'sh7FFFFFFF;
				else if (pr_t < -48'sh80000000)
					res_q.pressure_pascal <= -32'sh80000000;
				else
					res_q.pressure_pascal <= 32'(pr_t);
			end
			default: ;
		endcase
	end
endmodule

// File: rtl/bck_queue.sv
// Two-entry queue between front and back.
// Depends on bck_pkg.
module bck_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bck_pkg::comp_word_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bck_pkg::comp_word_t out_data
);
	bck_pkg::comp_word_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	ap_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	ap_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("full queue changed");
	ap_empty_novalid: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !out_valid) else $error("valid on empty queue");
endmodule

// File: rtl/bck_back.sv
// Back end: scalar Kalman update with a serial restoring divider for the gain.
// Depends on bck_pkg.
module bck_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bck_pkg::comp_word_t in_data,
	input  logic [31:0]         q,
	input  logic [31:0]         r,
	output logic                out_valid,
	input  logic                out_ready,
	output bck_pkg::out_word_t  out_data
);
	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001,
		B_PREP = 7'b0000010,
		B_DIV  = 7'b0000100,
		B_MUL  = 7'b0001000,
		B_PRD  = 7'b0010000,
		B_UPD  = 7'b0100000,
		B_OUT  = 7'b1000000
	} bstate_t;

	bstate_t state_q;
	logic seeded_q;
	logic signed [39:0] est_q;
	logic [31:0] cov_q;
	bck_pkg::comp_word_t cur_q;
	logic [31:0] p1_q;
	logic [32:0] den_q;
	logic [32:0] rem_q;
	logic [16:0] quo_q;
	logic [4:0] cnt_q;
	logic [15:0] k_q;
	logic signed [41:0] diff_q;
	logic signed [58:0] kd_q;
	logic [48:0] pc_q;
	logic signed [39:0] m_w, eb_w;
	logic [32:0] p1sum_w;
	logic [33:0] trial_w;
	logic signed [42:0] x_w;

	assign m_w = {cur_q.pressure_pascal, 8'd0};
	assign eb_w = seeded_q ? est_q : m_w;
	assign p1sum_w = {1'b0, cov_q} + {1'b0, q};
	assign trial_w = {rem_q, 1'b0} - {1'b0, den_q};
	assign x_w = 43'(eb_w) + 43'(kd_q >>> 16);

	assign in_ready = (state_q == B_IDLE);
	assign out_valid = (state_q == B_OUT);
	assign out_data.temperature_tenths = cur_q.temperature_tenths;
	assign out_data.pressure_pascal = cur_q.pressure_pascal;
	assign out_data.filtered_pressure = est_q;

	// Control and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			seeded_q <= 1'b0;
			est_q <= '0;
			cov_q <= bck_pkg::COV_RESET;
			cnt_q <= '0;
		end else begin
			case (state_q)
				B_IDLE: if (in_valid) state_q <= B_PREP;
				B_PREP: begin
					state_q <= B_DIV;
					cnt_q <= 5'd0;
				end
				B_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) state_q <= B_MUL;
				end
				B_MUL: state_q <= B_PRD;
				B_PRD: state_q <= B_UPD;
				B_UPD: begin
					if (x_w > 43'sh7FFFFFFFFF) est_q <= 40'sh7FFFFFFFFF;
					else if (x_w < -43'sh8000000000) est_q <= -40'sh8000000000;
					else est_q <= 40'(x_w);
					seeded_q <= 1'b1;
					cov_q <= pc_q[47:16];
					state_q <= B_OUT;
				end
				B_OUT: if (out_ready) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Input capture and gain division (p1 << 16) / (p1 + r), one quotient bit a cycle.
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: cur_q <= in_data;
			B_PREP: begin
				p1_q <= p1sum_w[32] ? 32'hFFFFFFFF : p1sum_w[31:0];
				den_q <= (p1sum_w[32] ? 33'h0FFFFFFFF : p1sum_w) + {1'b0, r};
				rem_q <= '0;
				quo_q <= '0;
			end
			B_DIV: begin
				if (cnt_q == 5'd0) begin
					// Remainder starts at p1; bit 16 flags p1 reaching the divisor.
					rem_q <= {1'b0, p1_q};
					quo_q <= {({1'b0, p1_q} >= den_q), 16'd0};
				end else begin
					if (!trial_w[33]) begin
						rem_q <= trial_w[32:0];
						quo_q <= {quo_q[16], quo_q[14:0], 1'b1};
					end else begin
						rem_q <= {rem_q[31:0], 1'b0};
						quo_q <= {quo_q[16], quo_q[14:0], 1'b0};
					end
				end
			end
			B_MUL: begin
				// Gain saturates when p1 reaches p1 + r; zero denominator gives 0.
				if (den_q == 33'd0) k_q <= 16'd0;
				else if (quo_q[16]) k_q <= 16'hFFFF;
				else k_q <= quo_q[15:0];
				diff_q <= 42'(m_w) - 42'(eb_w);
			end
			default: ;
		endcase
	end

	// Products registered in the cycle after the gain settles.
	always_ff @(posedge clk) begin
		kd_q <= 59'($signed({1'b0, k_q}) * diff_q);
		pc_q <= 49'((17'h10000 - {1'b0, k_q}) * p1_q);
	end

	ap_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_OUT) |-> seeded_q) else $error("estimate not seeded");
	ap_cov_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE) |=> $stable(cov_q)) else $error("covariance moved while idle");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(est_q))
		else $error("result changed under stall");
endmodule
